FILE: rtl/etc1_solid_color_block_encoder_core_assert.svh
// Assertion macros shared by the ETC1 solid-colour encoder RTL.
`ifndef ETC1_SOLID_COLOR_BLOCK_ENCODER_CORE_ASSERT_SVH
`define ETC1_SOLID_COLOR_BLOCK_ENCODER_CORE_ASSERT_SVH

// Same-cycle implication, clocked on clk, quiet during rst.
`define ECS_ASSERT_IMPL(label, ante, cons) \
  label: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) \
    else $error("same-cycle check failed");

// Next-cycle implication, clocked on clk, quiet during rst.
`define ECS_ASSERT_NEXT(label, ante, cons) \
  label: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) \
    else $error("next-cycle check failed");

`endif

FILE: rtl/etc1sc_pkg.sv
// Types and constants for the ETC1 solid-colour block encoder.
`default_nettype none

package etc1sc_pkg;

  localparam int NUM_TABLES  = 8;
  localparam int NUM_INDICES = 4;
  localparam int NUM_ENTRIES = NUM_TABLES * NUM_INDICES;

  typedef logic [7:0]        chan_t;
  typedef logic [4:0]        q5_t;
  typedef logic [9:0]        score_t;   // three 8-bit errors, at most 765
  typedef logic signed [8:0] mod_t;
  typedef logic [2:0]        table_t;
  typedef logic [1:0]        index_t;

  // Low two bits of the high word: diff bit set, flip bit clear
  localparam logic [1:0] DIFF_FLIP = 2'b10;

  // Modifier rows, indexed [table][pixel index]
  localparam mod_t MOD_TABLE [NUM_TABLES][NUM_INDICES] = '{
    '{ 9'sd2,   9'sd8,   -9'sd2,  -9'sd8   },
    '{ 9'sd5,   9'sd17,  -9'sd5,  -9'sd17  },
    '{ 9'sd9,   9'sd29,  -9'sd9,  -9'sd29  },
    '{ 9'sd13,  9'sd42,  -9'sd13, -9'sd42  },
    '{ 9'sd18,  9'sd60,  -9'sd18, -9'sd60  },
    '{ 9'sd24,  9'sd80,  -9'sd24, -9'sd80  },
    '{ 9'sd33,  9'sd106, -9'sd33, -9'sd106 },
    '{ 9'sd47,  9'sd183, -9'sd47, -9'sd183 }
  };

endpackage

`default_nettype wire

FILE: rtl/etc1_solid_color_block_encoder_core.sv
// ETC1 solid-colour block encoder: four-stage pipeline from RGB beat to 64-bit block.
// Each beat is registered in stages 1 to 4 in turn; m_axis_tvalid is stage 4's valid.
// Throughput: one beat per cycle when not stalled; each stage holds its beat only while
// the stage after it is full and stalled, so bubbles close up under back-pressure.
// Stages: quantise, 32 candidate scores, best index per table, best table.
// Reset: rst (synchronous, active high) clears all stage valid bits.
`default_nettype none
`include "etc1_solid_color_block_encoder_core_assert.svh"

module etc1_solid_color_block_encoder_core (
  input  wire logic        clk,
  input  wire logic        rst,
  input  wire logic        s_axis_tvalid,
  output logic             s_axis_tready,
  input  wire logic [23:0] s_axis_tdata,   // red[7:0], green[15:8], blue[23:16]
  output logic             m_axis_tvalid,
  input  wire logic        m_axis_tready,
  output logic [63:0]      m_axis_tdata    // block_high_word[31:0], block_low_word[63:32]
);
  import etc1sc_pkg::*;

  // Stage valid bits and advance enables
  logic v1, v2, v3, v4;
  logic en1, en2, en3, en4;

  assign en4 = !v4 || m_axis_tready;
  assign en3 = !v3 || en4;
  assign en2 = !v2 || en3;
  assign en1 = !v1 || en2;
  assign s_axis_tready = en1;
  assign m_axis_tvalid = v4;

  always_ff @(posedge clk) begin
    if (rst) begin
      v1 <= 1'b0;
      v2 <= 1'b0;
      v3 <= 1'b0;
      v4 <= 1'b0;
    end else begin
      if (en1) v1 <= s_axis_tvalid;
      if (en2) v2 <= v1;
      if (en3) v3 <= v2;
      if (en4) v4 <= v3;
    end
  end

  // Stage 1: quantise each channel to 5 bits, round(31*c/255)
  chan_t in_chan [3];
  q5_t   in_q5   [3];
  chan_t s1_orig [3];
  q5_t   s1_q5   [3];

  always_comb begin
    logic [12:0] p;
    logic [12:0] ps;
    for (int k = 0; k < 3; k++) begin
      in_chan[k] = s_axis_tdata[8*k +: 8];
      p  = 13'(in_chan[k]) * 13'd31 + 13'd128;
      ps = p + (p >> 8);
      in_q5[k] = ps[12:8];
    end
  end

  always_ff @(posedge clk) begin
    if (en1) begin
      s1_orig <= in_chan;
      s1_q5   <= in_q5;
    end
  end

  // Stage 2: absolute-error score of all 32 modifier entries
  score_t s2_score [NUM_ENTRIES];
  score_t sc_next  [NUM_ENTRIES];
  q5_t    s2_q5    [3];

  always_comb begin
    logic [9:0] sum;
    chan_t      ex;
    chan_t      cl;
    chan_t      ad;
    for (int t = 0; t < NUM_TABLES; t++) begin
      for (int i = 0; i < NUM_INDICES; i++) begin
        sc_next[t*NUM_INDICES + i] = '0;
        for (int k = 0; k < 3; k++) begin
          ex  = {s1_q5[k], s1_q5[k][4:2]};
          sum = {2'b00, ex} + 10'(MOD_TABLE[t][i]);
          if (sum[9])      cl = 8'd0;
          else if (sum[8]) cl = 8'd255;
          else             cl = sum[7:0];
          ad = (s1_orig[k] > cl) ? (s1_orig[k] - cl) : (cl - s1_orig[k]);
          sc_next[t*NUM_INDICES + i] = sc_next[t*NUM_INDICES + i] + 10'(ad);
        end
      end
    end
  end

  always_ff @(posedge clk) begin
    if (en2) begin
      s2_score <= sc_next;
      s2_q5    <= s1_q5;
    end
  end

  // Stage 3: best pixel index within each table, first minimum kept
  score_t s3_tscore [NUM_TABLES];
  index_t s3_tidx   [NUM_TABLES];
  q5_t    s3_q5     [3];
  score_t ts_next   [NUM_TABLES];
  index_t ti_next   [NUM_TABLES];

  always_comb begin
    for (int t = 0; t < NUM_TABLES; t++) begin
      ts_next[t] = s2_score[t*NUM_INDICES];
      ti_next[t] = '0;
      for (int i = 1; i < NUM_INDICES; i++) begin
        if (s2_score[t*NUM_INDICES + i] < ts_next[t]) begin
          ts_next[t] = s2_score[t*NUM_INDICES + i];
          ti_next[t] = index_t'(i);
        end
      end
    end
  end

  always_ff @(posedge clk) begin
    if (en3) begin
      s3_tscore <= ts_next;
      s3_tidx   <= ti_next;
      s3_q5     <= s2_q5;
    end
  end

  // Stage 4: best table, lower table wins a tie
  score_t s4_score;
  table_t s4_table;
  index_t s4_idx;
  q5_t    s4_q5 [3];
  score_t bs_next;
  table_t bt_next;
  index_t bi_next;

  always_comb begin
    bs_next = s3_tscore[0];
    bt_next = '0;
    bi_next = s3_tidx[0];
    for (int t = 1; t < NUM_TABLES; t++) begin
      if (s3_tscore[t] < bs_next) begin
        bs_next = s3_tscore[t];
        bt_next = table_t'(t);
        bi_next = s3_tidx[t];
      end
    end
  end

  always_ff @(posedge clk) begin
    if (en4) begin
      s4_score <= bs_next;
      s4_table <= bt_next;
      s4_idx   <= bi_next;
      s4_q5    <= s3_q5;
    end
  end

  // Block packing, both words byte-swapped as stored
  logic [31:0] high_word;
  logic [31:0] low_word;

  assign high_word = {s4_table, s4_table, DIFF_FLIP,
                      s4_q5[2], 3'b000,
                      s4_q5[1], 3'b000,
                      s4_q5[0], 3'b000};
  assign low_word  = {{16{s4_idx[0]}}, {16{s4_idx[1]}}};
  assign m_axis_tdata = {low_word, high_word};

  // Assertions
  `ECS_ASSERT_IMPL(a_full_when_not_ready, !s_axis_tready,
                   v1 && v2 && v3 && v4 && !m_axis_tready)
  `ECS_ASSERT_NEXT(a_stage2_holds, v2 && !en3,
                   v2 && $stable(s2_q5[0]) && $stable(s2_score[0]))
  `ECS_ASSERT_NEXT(a_best_not_worse, v3 && en4,
                   v4 && (s4_score <= $past(s3_tscore[0])))
  `ECS_ASSERT_NEXT(a_table0_bound, v2 && en3,
                   v3 && (s3_tscore[0] <= $past(s2_score[0])))

endmodule

`default_nettype wire

FILE: verif/etc1_solid_color_block_encoder_core_checker.sv
// Scoreboard for the ETC1 solid-colour encoder: predicts each block and checks the output beats.
`timescale 1ns / 1ps

module etc1_solid_color_block_encoder_core_checker (
  input  logic        clk,
  input  logic        rst,
  input  logic        s_valid,
  input  logic        s_ready,
  input  logic [23:0] s_data,    // red[7:0], green[15:8], blue[23:16]
  input  logic        m_valid,
  input  logic        m_ready,
  input  logic [63:0] m_data,    // block_high_word[31:0], block_low_word[63:32]
  output int          fail_count,
  output int          outstanding,
  output int          checked_count
);
  import etc1sc_pkg::*;

  // Blocks predicted from accepted colour beats, oldest first
  logic [63:0] expected_blocks [$];

  // Modifier value for a table row and pixel index
  function automatic int modifier_for(input int row, input int idx);
    int near_mag;
    int far_mag;
    case (row)
      0: begin near_mag = 2;  far_mag = 8;   end
      1: begin near_mag = 5;  far_mag = 17;  end
      2: begin near_mag = 9;  far_mag = 29;  end
      3: begin near_mag = 13; far_mag = 42;  end
      4: begin near_mag = 18; far_mag = 60;  end
      5: begin near_mag = 24; far_mag = 80;  end
      6: begin near_mag = 33; far_mag = 106; end
      default: begin near_mag = 47; far_mag = 183; end
    endcase
    case (idx)
      0: return near_mag;
      1: return far_mag;
      2: return -near_mag;
      default: return -far_mag;
    endcase
  endfunction

  // Words are stored little-end first
  function automatic logic [31:0] byte_swap(input logic [31:0] v);
    return {v[7:0], v[15:8], v[23:16], v[31:24]};
  endfunction

  // Full block for one fill colour: {low word, high word}, both as stored
  function automatic logic [63:0] encode_fill_block(input chan_t red, input chan_t green,
                                                    input chan_t blue);
    int          orig [3];
    int          expd [3];
    q5_t         q5 [3];
    int          p;
    int          v;
    int          score;
    int          best;
    table_t      best_row;
    index_t      best_idx;
    logic [31:0] high_word;
    logic [31:0] low_word;
    orig[0] = int'(red);
    orig[1] = int'(green);
    orig[2] = int'(blue);
    // round(31*c/255), then back to 8 bits by replicating the top bits
    for (int k = 0; k < 3; k++) begin
      p = 31 * orig[k] + 128;
      q5[k] = q5_t'((p + (p >> 8)) >> 8);
      expd[k] = int'({q5[k], q5[k][4:2]});
    end
    // Exhaustive search; strict less-than keeps the earliest entry on a tie
    best = 1024;
    best_row = '0;
    best_idx = '0;
    for (int row = 0; row < 8; row++) begin
      for (int idx = 0; idx < 4; idx++) begin
        score = 0;
        for (int k = 0; k < 3; k++) begin
          v = expd[k] + modifier_for(row, idx);
          if (v < 0) v = 0;
          if (v > 255) v = 255;
          score += (orig[k] > v) ? orig[k] - v : v - orig[k];
        end
        if (score < best) begin
          best = score;
          best_row = table_t'(row);
          best_idx = index_t'(idx);
        end
      end
    end
    // Differential mode, zero deltas, same codeword in both halves
    high_word = (32'(q5[0]) << 27) | (32'(q5[1]) << 19) | (32'(q5[2]) << 11) |
                (32'(best_row) << 5) | (32'(best_row) << 2) | 32'(DIFF_FLIP);
    low_word = {best_idx[1] ? 16'hFFFF : 16'h0000, best_idx[0] ? 16'hFFFF : 16'h0000};
    return {byte_swap(low_word), byte_swap(high_word)};
  endfunction

  // Predict on input beats, compare on output beats
  always @(posedge clk) begin : watch_beats
    logic [63:0] want;
    if (rst) begin
      expected_blocks.delete();
      fail_count    = 0;
      outstanding   = 0;
      checked_count = 0;
    end else begin
      if (s_valid && s_ready)
        expected_blocks.insert(expected_blocks.size(),
                               encode_fill_block(s_data[7:0], s_data[15:8], s_data[23:16]));
      if (m_valid && m_ready) begin
        if (expected_blocks.size() == 0) begin
          $display("%0t: output beat with nothing pending, got %h", $time, m_data);
          fail_count++;
        end else begin
          want = expected_blocks.pop_front();
          checked_count++;
          if (m_data[31:0] !== want[31:0]) begin
            $display("%0t: block_high_word expected %h got %h", $time, want[31:0],
                     m_data[31:0]);
            fail_count++;
          end
          if (m_data[63:32] !== want[63:32]) begin
            $display("%0t: block_low_word expected %h got %h", $time, want[63:32],
                     m_data[63:32]);
            fail_count++;
          end
        end
      end
      outstanding = expected_blocks.size();
    end
  end

endmodule

FILE: verif/etc1_solid_color_block_encoder_core_tb.sv
// Testbench top for the ETC1 solid-colour encoder: clock, reset, colour stimulus and verdict.
`timescale 1ns / 1ps

module etc1_solid_color_block_encoder_core_tb;
  import etc1sc_pkg::*;

  logic        clk = 1'b0;
  logic        rst = 1'b1;
  logic        s_axis_tvalid = 1'b0;
  logic        s_axis_tready;
  logic [23:0] s_axis_tdata = '0;   // red[7:0], green[15:8], blue[23:16]
  logic        m_axis_tvalid;
  logic        m_axis_tready = 1'b0;
  logic [63:0] m_axis_tdata;        // block_high_word[31:0], block_low_word[63:32]

  int fail_count;
  int outstanding;
  int checked_count;

  int colours_sent   = 0;
  int directed_count = 0;
  int hold_cycles    = 0;
  bit calm           = 1'b0;  // no idling on either side
  bit steady_stretch = 1'b0;  // sender offers back to back

  etc1_solid_color_block_encoder_core i_dut (
    .clk           (clk),
    .rst           (rst),
    .s_axis_tvalid (s_axis_tvalid),
    .s_axis_tready (s_axis_tready),
    .s_axis_tdata  (s_axis_tdata),
    .m_axis_tvalid (m_axis_tvalid),
    .m_axis_tready (m_axis_tready),
    .m_axis_tdata  (m_axis_tdata)
  );

  etc1_solid_color_block_encoder_core_checker i_checker (
    .clk           (clk),
    .rst           (rst),
    .s_valid       (s_axis_tvalid),
    .s_ready       (s_axis_tready),
    .s_data        (s_axis_tdata),
    .m_valid       (m_axis_tvalid),
    .m_ready       (m_axis_tready),
    .m_data        (m_axis_tdata),
    .fail_count    (fail_count),
    .outstanding   (outstanding),
    .checked_count (checked_count)
  );

  // 12 ns clock
  always begin
    #6 clk = 1'b1;
    #6 clk = 1'b0;
  end

  // Watchdog
  initial begin
    #6_000_000;
    $display("== FAIL ==");
    $finish;
  end

  // Offer one colour beat, with an occasional gap before it; returns once accepted
  task automatic send_colour(input chan_t red, input chan_t green, input chan_t blue);
    int gap;
    gap = 0;
    if (!calm && !steady_stretch && $urandom_range(0, 7) == 0)
      gap = $urandom_range(1, 14);
    if (gap > 0) begin
      @(negedge clk) s_axis_tvalid <= 1'b0;
      repeat (gap - 1) @(negedge clk);
    end
    @(negedge clk) begin
      s_axis_tvalid <= 1'b1;
      s_axis_tdata  <= {blue, green, red};
    end
    do @(posedge clk); while (!s_axis_tready);
    colours_sent++;
  endtask

  // Values around quantiser steps and the range ends
  function automatic chan_t pick_corner();
    case ($urandom_range(0, 7))
      0: return 8'd0;
      1: return 8'd255;
      2: return chan_t'($urandom_range(0, 3));
      3: return chan_t'($urandom_range(252, 255));
      4: return chan_t'($urandom_range(120, 135));
      5: return chan_t'($urandom_range(0, 31) * 8 + $urandom_range(0, 7));
      6: return 8'd4;
      default: return 8'd5;
    endcase
  endfunction

  // Receiver: random ready bursts, one long hold-off, then always ready
  initial begin : sink
    int run_len;
    int stall_len;
    do @(negedge clk); while (rst);
    forever begin
      if (!calm && hold_cycles == 0 && colours_sent >= 400) begin
        @(negedge clk) m_axis_tready <= 1'b0;
        // long back-pressure so the pipeline fills and stalls its input
        while (hold_cycles < 300) begin
          @(negedge clk);
          hold_cycles++;
        end
      end else if (calm) begin
        @(negedge clk) m_axis_tready <= 1'b1;
      end else begin
        run_len = ($urandom_range(0, 5) == 0) ? $urandom_range(60, 150) : $urandom_range(1, 40);
        stall_len = $urandom_range(1, 14);
        @(negedge clk) m_axis_tready <= 1'b1;
        repeat (run_len - 1) @(negedge clk);
        @(negedge clk) m_axis_tready <= 1'b0;
        repeat (stall_len - 1) @(negedge clk);
      end
    end
  end

  // Stimulus and verdict
  initial begin : source
    chan_t r;
    chan_t g;
    chan_t b;
    repeat (4) @(posedge clk);
    @(negedge clk) rst <= 1'b0;

    // Directed: range ends, primaries, greys that tie, quantiser midpoints
    send_colour(8'd0,   8'd0,   8'd0);
    send_colour(8'd255, 8'd255, 8'd255);
    send_colour(8'd255, 8'd0,   8'd0);
    send_colour(8'd0,   8'd255, 8'd0);
    send_colour(8'd0,   8'd0,   8'd255);
    send_colour(8'd255, 8'd255, 8'd0);
    send_colour(8'd0,   8'd255, 8'd255);
    send_colour(8'd128, 8'd128, 8'd128);
    send_colour(8'd127, 8'd127, 8'd127);
    send_colour(8'd1,   8'd2,   8'd3);
    send_colour(8'd254, 8'd253, 8'd252);
    send_colour(8'd4,   8'd5,   8'd12);
    send_colour(8'd13,  8'd123, 8'd132);
    send_colour(8'd8,   8'd8,   8'd8);
    send_colour(8'd66,  8'd66,  8'd66);
    send_colour(8'd0,   8'd128, 8'd255);
    send_colour(8'd200, 8'd40,  8'd100);
    send_colour(8'hAA,  8'h55,  8'hAA);
    send_colour(8'h55,  8'hAA,  8'h55);
    send_colour(8'd250, 8'd3,   8'd250);
    directed_count = colours_sent;

    // Random: mostly free colours, plus greys and quantiser corners
    for (int n = 0; n < 2000; n++) begin
      calm = (n >= 1800);
      steady_stretch = (n >= 900 && n < 1100);
      case ($urandom_range(0, 9))
        0, 1, 2, 3, 4, 5: begin
          r = chan_t'($urandom);
          g = chan_t'($urandom);
          b = chan_t'($urandom);
        end
        6, 7: begin
          r = chan_t'($urandom);
          g = r;
          b = r;
        end
        default: begin
          r = pick_corner();
          g = pick_corner();
          b = pick_corner();
        end
      endcase
      send_colour(r, g, b);
    end

    @(negedge clk) s_axis_tvalid <= 1'b0;
    wait (outstanding == 0);
    repeat (10) @(posedge clk);

    $display("Encoded %0d colours (%0d directed, rest random incl. greys and quantiser corners).",
             colours_sent, directed_count);
    $display("Checked %0d blocks under random stalls and one %0d-cycle output hold-off.",
             checked_count, hold_cycles);
    if (fail_count == 0 && outstanding == 0)
      $display("== PASS ==");
    else
      $display("== FAIL ==");
    $finish;
  end

endmodule
